FILE: hdl/assert_macros.svh
// Assertion helpers shared by the filter modules.
// Every check is clocked on clk_i and is switched off while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ASSERT_NOW(lbl, ante, cons, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

FILE: hdl/sgcd_pkg.sv
package sgcd_pkg;

  // Default build settings of the filter.
  localparam int WINDOW_POINTS_DEF  = 51;
  localparam int SAMPLE_WIDTH_DEF   = 16;
  localparam int COEF_FRAC_BITS_DEF = 40;

  // Fixed field widths of the two channels.
  localparam int IN_SAMPLE_W = 16;
  localparam int OUT_W       = 56;

  // Coefficients are split into a high and a low part at this bit.
  localparam int LO_BITS = 25;

  // Largest half window over the whole window range, sizes the zero counter.
  localparam int MAX_HALF = 31;
  localparam int ZCNT_W   = $clog2(MAX_HALF + 1);

  localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  // One input request.
  typedef struct packed {
    logic signed [IN_SAMPLE_W-1:0] sample;
    logic                          record_end;
  } sgcd_in_t;

  // One result request.
  typedef struct packed {
    logic signed [OUT_W-1:0] first_derivative;
    logic signed [OUT_W-1:0] second_derivative;
    logic                    final_result;
  } sgcd_out_t;

  // Results caused by one accepted sample, handed to the output sequencer.
  typedef struct packed {
    logic              load;
    logic              main;
    logic              fir;
    logic [ZCNT_W-1:0] zeros;
    logic              fin;
  } sgcd_burst_t;

  // Rounds num * 2^frac / den to the nearest integer, ties away from zero.
  // Long division one bit at a time, evaluated at elaboration.
  function automatic longint sgcd_fix_div(input longint num, input longint den,
                                          input int frac);
    logic [63:0] mag;
    logic [63:0] dv;
    logic [63:0] rem;
    logic [63:0] quo;
    logic        neg;
    longint      res;
    neg = (num < 0);
    mag = neg ? 64'(-num) : 64'(num);
    dv  = 64'(den);
    rem = '0;
    quo = '0;
    res = 0;
    if (dv != 64'd0) begin
      for (int b = 63; b >= 0; b--) begin
        rem = {rem[62:0], mag[b]};
        quo = {quo[62:0], 1'b0};
        if (rem >= dv) begin
          rem    = rem - dv;
          quo[0] = 1'b1;
        end
      end
      for (int b = 0; b <= frac; b++) begin
        rem = {rem[62:0], 1'b0};
        quo = {quo[62:0], 1'b0};
        if (rem >= dv) begin
          rem    = rem - dv;
          quo[0] = 1'b1;
        end
      end
      quo = (quo + 64'd1) >> 1;
      res = neg ? -longint'(quo) : longint'(quo);
    end
    return res;
  endfunction

  // Cubic first derivative coefficient for tap j of a window of m points.
  function automatic longint sgcd_coef_d1(input int m, input int half, input int j,
                                          input int frac);
    longint mm;
    longint m2;
    longint m4;
    longint i;
    longint den;
    longint num;
    mm  = longint'(m);
    m2  = mm * mm;
    m4  = m2 * m2;
    i   = longint'(j) - longint'(half);
    den = mm * (m2 - 1) * (3 * m4 - 39 * m2 + 108);
    num = 15 * (5 * (3 * m4 - 18 * m2 + 31) * i - 28 * (3 * m2 - 7) * i * i * i);
    return sgcd_fix_div(num, den, frac);
  endfunction

  // Cubic second derivative coefficient for tap j of a window of m points.
  function automatic longint sgcd_coef_d2(input int m, input int half, input int j,
                                          input int frac);
    longint mm;
    longint m2;
    longint i;
    longint den;
    longint num;
    mm  = longint'(m);
    m2  = mm * mm;
    i   = longint'(j) - longint'(half);
    den = mm * (m2 - 1) * (m2 - 4);
    num = 30 * (12 * i * i - (m2 - 1));
    return sgcd_fix_div(num, den, frac);
  endfunction

endpackage

FILE: hdl/sgcd_cell.sv
module sgcd_cell import sgcd_pkg::*; #(
  parameter longint COEF_D1        = 0,
  parameter longint COEF_D2        = 0,
  parameter int     SAMPLE_WIDTH   = SAMPLE_WIDTH_DEF,
  parameter int     COEF_FRAC_BITS = COEF_FRAC_BITS_DEF,
  parameter int     HI_ACC_W       = 48,
  parameter int     LO_ACC_W       = 48
) (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_i,
  input  logic signed [HI_ACC_W-1:0]     d1_hi_i,
  input  logic signed [LO_ACC_W-1:0]     d1_lo_i,
  input  logic signed [HI_ACC_W-1:0]     d2_hi_i,
  input  logic signed [LO_ACC_W-1:0]     d2_lo_i,
  output logic signed [HI_ACC_W-1:0]     d1_hi_o,
  output logic signed [LO_ACC_W-1:0]     d1_lo_o,
  output logic signed [HI_ACC_W-1:0]     d2_hi_o,
  output logic signed [LO_ACC_W-1:0]     d2_lo_o
);

  // Coefficient magnitudes stay below one, so the high part needs few bits.
  localparam int     HI_W    = ((COEF_FRAC_BITS > LO_BITS) ? COEF_FRAC_BITS - LO_BITS : 1) + 1;
  localparam int     LO_W    = LO_BITS + 1;
  localparam longint LO_MASK = (longint'(1) <<< LO_BITS) - 1;

  localparam longint MAG1 = (COEF_D1 < 0) ? -COEF_D1 : COEF_D1;
  localparam longint MAG2 = (COEF_D2 < 0) ? -COEF_D2 : COEF_D2;

  // Both parts carry the sign of the whole coefficient.
  localparam logic signed [HI_W-1:0] HI1 =
    HI_W'((COEF_D1 < 0) ? -(MAG1 >>> LO_BITS) : (MAG1 >>> LO_BITS));
  localparam logic signed [LO_W-1:0] LO1 =
    LO_W'((COEF_D1 < 0) ? -(MAG1 & LO_MASK) : (MAG1 & LO_MASK));
  localparam logic signed [HI_W-1:0] HI2 =
    HI_W'((COEF_D2 < 0) ? -(MAG2 >>> LO_BITS) : (MAG2 >>> LO_BITS));
  localparam logic signed [LO_W-1:0] LO2 =
    LO_W'((COEF_D2 < 0) ? -(MAG2 & LO_MASK) : (MAG2 & LO_MASK));

  logic signed [HI_W+SAMPLE_WIDTH-1:0] d1_hi_prod;
  logic signed [LO_W+SAMPLE_WIDTH-1:0] d1_lo_prod;
  logic signed [HI_W+SAMPLE_WIDTH-1:0] d2_hi_prod;
  logic signed [LO_W+SAMPLE_WIDTH-1:0] d2_lo_prod;

  logic signed [HI_ACC_W-1:0] d1_hi_d, d1_hi_q;
  logic signed [LO_ACC_W-1:0] d1_lo_d, d1_lo_q;
  logic signed [HI_ACC_W-1:0] d2_hi_d, d2_hi_q;
  logic signed [LO_ACC_W-1:0] d2_lo_d, d2_lo_q;

  // Tap products of the new sample with this cell's coefficient parts.
  assign d1_hi_prod = sample_i * HI1;
  assign d1_lo_prod = sample_i * LO1;
  assign d2_hi_prod = sample_i * HI2;
  assign d2_lo_prod = sample_i * LO2;

  // Add the products to the partial sums handed over by the older neighbor.
  assign d1_hi_d = d1_hi_i + HI_ACC_W'(d1_hi_prod);
  assign d1_lo_d = d1_lo_i + LO_ACC_W'(d1_lo_prod);
  assign d2_hi_d = d2_hi_i + HI_ACC_W'(d2_hi_prod);
  assign d2_lo_d = d2_lo_i + LO_ACC_W'(d2_lo_prod);

  // Partial sums move one cell along on every accepted sample.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d1_hi_q <= d1_hi_d;
      d1_lo_q <= d1_lo_d;
      d2_hi_q <= d2_hi_d;
      d2_lo_q <= d2_lo_d;
    end
  end

  assign d1_hi_o = d1_hi_q;
  assign d1_lo_o = d1_lo_q;
  assign d2_hi_o = d2_hi_q;
  assign d2_lo_o = d2_lo_q;

endmodule

FILE: hdl/sgcd_out.sv
`include "assert_macros.svh"

module sgcd_out import sgcd_pkg::*; #(
  parameter int HI_ACC_W = 48,
  parameter int LO_ACC_W = 48
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  sgcd_burst_t                burst_i,
  input  logic signed [HI_ACC_W-1:0] d1_hi_i,
  input  logic signed [LO_ACC_W-1:0] d1_lo_i,
  input  logic signed [HI_ACC_W-1:0] d2_hi_i,
  input  logic signed [LO_ACC_W-1:0] d2_lo_i,
  output logic                       in_stall_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output sgcd_out_t                  out_rsp_o
);

  localparam int TOT_W = ((HI_ACC_W + LO_BITS > LO_ACC_W) ? HI_ACC_W + LO_BITS : LO_ACC_W) + 1;
  localparam int SAT_W = (TOT_W > OUT_W) ? TOT_W : OUT_W;

  // Clamps an exact sum to the signed output range.
  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [SAT_W-1:0] v);
    logic [SAT_W-OUT_W:0]    upper;
    logic signed [OUT_W-1:0] res;
    upper = v[SAT_W-1:OUT_W-1];
    if ((&upper) || !(|upper)) begin
      res = v[OUT_W-1:0];
    end else if (v[SAT_W-1]) begin
      res = OUT_MIN;
    end else begin
      res = OUT_MAX;
    end
    return res;
  endfunction

  logic              main_d, main_q;
  logic              fir_d, fir_q;
  logic [ZCNT_W-1:0] zeros_d, zeros_q;
  logic              fin_d, fin_q;
  logic              out_valid_d, out_valid_q;
  sgcd_out_t         rsp_d, rsp_q;

  logic                    busy;
  logic                    load;
  logic                    single;
  logic signed [SAT_W-1:0] d1_tot;
  logic signed [SAT_W-1:0] d2_tot;

  // Results still owed for the last accepted sample.
  assign busy   = main_q || (zeros_q != '0);
  assign load   = busy && (!out_valid_q || !out_stall_i);
  assign single = main_q ? (zeros_q == '0) : (zeros_q == ZCNT_W'(1));

  // A new sample may enter only once its predecessor's burst leaves this cycle.
  assign in_stall_o = busy && !(load && single);

  // Join the high and low partial sums.
  assign d1_tot = (SAT_W'(d1_hi_i) <<< LO_BITS) + SAT_W'(d1_lo_i);
  assign d2_tot = (SAT_W'(d2_hi_i) <<< LO_BITS) + SAT_W'(d2_lo_i);

  // Burst bookkeeping: the centered result first, then the trailing zeros.
  always_comb begin
    main_d  = main_q;
    fir_d   = fir_q;
    zeros_d = zeros_q;
    fin_d   = fin_q;
    priority if (burst_i.load) begin
      main_d  = burst_i.main;
      fir_d   = burst_i.fir;
      zeros_d = burst_i.zeros;
      fin_d   = burst_i.fin;
    end else if (load) begin
      if (main_q) begin
        main_d = 1'b0;
      end else begin
        zeros_d = zeros_q - ZCNT_W'(1);
      end
    end else begin
      main_d = main_q;
    end
  end

  // Next output request.
  always_comb begin
    rsp_d.first_derivative  = (main_q && fir_q) ? sat_out(d1_tot) : '0;
    rsp_d.second_derivative = (main_q && fir_q) ? sat_out(d2_tot) : '0;
    rsp_d.final_result      = fin_q && single;
  end

  // Output register valid flag.
  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_q      <= 1'b0;
      fir_q       <= 1'b0;
      zeros_q     <= '0;
      fin_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      main_q      <= main_d;
      fir_q       <= fir_d;
      zeros_q     <= zeros_d;
      fin_q       <= fin_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      rsp_q <= rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

  // A new burst never overwrites results that are still owed.
  `ASSERT_NOW(a_no_overrun, burst_i.load, !busy || (load && single), "burst overwritten before it drained")
  // The last result of a record carries the final mark.
  `ASSERT_NEXT(a_final_marked, load && single && fin_q, out_valid_o && out_rsp_o.final_result, "final result not marked")
  // Trailing zeros are only owed at a record end.
  `ASSERT_NOW(a_zeros_at_end, busy && !fin_q, zeros_q == '0, "zero results pending without record end")

endmodule

FILE: hdl/savgol_cubic_derivative_fir.sv
// Cubic Savitzky-Golay first and second derivative filter.
//
// Input channel: in_valid_i / in_stall_o / in_req_i carry one signed sample
// per request, with record_end set on the last sample of a record.
// Output channel: out_valid_o / out_stall_i / out_rsp_o carry one result per
// sample position of the record; final_result marks the last one.
// A request moves at a clock edge where valid is high and stall is low.
//
// Each sample goes into a row of tap cells that pass partial sums along, so
// a sample can be taken in every cycle while nothing stalls. The result it
// completes is registered in the last tap cell and then in the output register.
// Without a stall, throughput is one sample per cycle; a record end also owes up to
// (WINDOW_POINTS-1)/2 trailing zero results, one per cycle, and in_stall_o
// stays high until all but the last of them have left for the output register.
// When the receiver stalls, the output register holds its request and at most
// one more burst waits behind it before the input is stalled.
// Reset clears the sample count and all pending results; no memory needs a
// clearing pass, so samples are accepted right after reset.
`include "assert_macros.svh"

module savgol_cubic_derivative_fir import sgcd_pkg::*; #(
  parameter int WINDOW_POINTS  = WINDOW_POINTS_DEF,
  parameter int SAMPLE_WIDTH   = SAMPLE_WIDTH_DEF,
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  sgcd_in_t  in_req_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output sgcd_out_t out_rsp_o
);

  localparam int HALF     = (WINDOW_POINTS - 1) / 2;
  localparam int TAPS     = 2 * HALF + 1;
  localparam int TAP_BITS = $clog2(TAPS);
  localparam int HI_W     = ((COEF_FRAC_BITS > LO_BITS) ? COEF_FRAC_BITS - LO_BITS : 1) + 1;
  localparam int LO_W     = LO_BITS + 1;
  localparam int HI_ACC_W = HI_W + SAMPLE_WIDTH + TAP_BITS;
  localparam int LO_ACC_W = LO_W + SAMPLE_WIDTH + TAP_BITS;
  localparam int SEEN_W   = $clog2(2 * HALF + 1);
  localparam int RAW_W    = (SAMPLE_WIDTH > IN_SAMPLE_W) ? SAMPLE_WIDTH : IN_SAMPLE_W;

  logic                           in_accept;
  logic [RAW_W-1:0]               raw;
  logic signed [SAMPLE_WIDTH-1:0] sample_s;
  logic [SEEN_W-1:0]              seen_d, seen_q;
  sgcd_burst_t                    burst;

  logic signed [HI_ACC_W-1:0] d1_hi [TAPS+1];
  logic signed [LO_ACC_W-1:0] d1_lo [TAPS+1];
  logic signed [HI_ACC_W-1:0] d2_hi [TAPS+1];
  logic signed [LO_ACC_W-1:0] d2_lo [TAPS+1];

  assign in_accept = in_valid_i && !in_stall_o;

  // The low SAMPLE_WIDTH bits of the zero-extended field form the sample.
  assign raw      = RAW_W'(unsigned'(in_req_i.sample));
  assign sample_s = signed'(raw[SAMPLE_WIDTH-1:0]);

  // Samples seen in this record, saturating once the window is full.
  always_comb begin
    seen_d = seen_q;
    if (in_accept) begin
      if (in_req_i.record_end) begin
        seen_d = '0;
      end else if (seen_q < SEEN_W'(2 * HALF)) begin
        seen_d = seen_q + SEEN_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= '0;
    end else begin
      seen_q <= seen_d;
    end
  end

  // Results owed for this sample: a centered result and, at a record end,
  // the zeros for the trailing positions.
  always_comb begin
    burst.load  = in_accept;
    burst.main  = (seen_q >= SEEN_W'(HALF));
    burst.fir   = (seen_q >= SEEN_W'(2 * HALF));
    burst.fin   = in_req_i.record_end;
    burst.zeros = '0;
    if (in_req_i.record_end) begin
      burst.zeros = (seen_q >= SEEN_W'(HALF)) ? ZCNT_W'(HALF)
                                              : ZCNT_W'(seen_q) + ZCNT_W'(1);
    end
  end

  // Row of tap cells, oldest tap first; the newest cell holds the full sum.
  assign d1_hi[0] = '0;
  assign d1_lo[0] = '0;
  assign d2_hi[0] = '0;
  assign d2_lo[0] = '0;

  for (genvar j = 0; j < TAPS; j++) begin : g_cell
    sgcd_cell #(
      .COEF_D1        (sgcd_coef_d1(WINDOW_POINTS, HALF, j, COEF_FRAC_BITS)),
      .COEF_D2        (sgcd_coef_d2(WINDOW_POINTS, HALF, j, COEF_FRAC_BITS)),
      .SAMPLE_WIDTH   (SAMPLE_WIDTH),
      .COEF_FRAC_BITS (COEF_FRAC_BITS),
      .HI_ACC_W       (HI_ACC_W),
      .LO_ACC_W       (LO_ACC_W)
    ) u_cell (
      .clk_i    (clk_i),
      .en_i     (in_accept),
      .sample_i (sample_s),
      .d1_hi_i  (d1_hi[j]),
      .d1_lo_i  (d1_lo[j]),
      .d2_hi_i  (d2_hi[j]),
      .d2_lo_i  (d2_lo[j]),
      .d1_hi_o  (d1_hi[j+1]),
      .d1_lo_o  (d1_lo[j+1]),
      .d2_hi_o  (d2_hi[j+1]),
      .d2_lo_o  (d2_lo[j+1])
    );
  end

  // Result sequencer, saturation and output register.
  sgcd_out #(
    .HI_ACC_W (HI_ACC_W),
    .LO_ACC_W (LO_ACC_W)
  ) u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .burst_i     (burst),
    .d1_hi_i     (d1_hi[TAPS]),
    .d1_lo_i     (d1_lo[TAPS]),
    .d2_hi_i     (d2_hi[TAPS]),
    .d2_lo_i     (d2_lo[TAPS]),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

  // A record end restarts the sample count.
  `ASSERT_NEXT(a_count_cleared, in_accept && in_req_i.record_end, seen_q == '0, "sample count not cleared at record end")
  // A filtered result is only owed together with a centered result.
  `ASSERT_NOW(a_fir_needs_main, burst.fir, burst.main, "filtered result without centered position")

endmodule

FILE: tb/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sgcd_pkg::*;

  localparam int HALF        = (WINDOW_POINTS_DEF - 1) / 2;
  localparam int TAPS        = 2 * HALF + 1;
  localparam int FRAC        = COEF_FRAC_BITS_DEF;
  localparam int RAND_ITEMS  = 330;
  localparam int PHASES      = 4;
  localparam int LINGER      = HALF + 8;
  localparam int CYCLE_LIMIT = 1000000;

  localparam logic signed [127:0] SAT_HI = 128'(OUT_MAX);
  localparam logic signed [127:0] SAT_LO = 128'(OUT_MIN);

  // Sender idle and receiver stall odds, in percent, for each random phase.
  localparam int SEND_IDLE [PHASES] = '{0, 84, 0, 19};
  localparam int RECV_STALL [PHASES] = '{0, 0, 84, 19};

  // One row of the directed table. Rows marked typed carry their expected
  // zero results directly: the count, with the flag on the last one when the
  // row closes its record.
  typedef struct packed {
    logic [15:0] sample;
    logic        last;
    logic        typed;
    logic [5:0]  zeros;
  } dir_row_t;

  localparam int DIR_ROWS = 9;
  localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
    // Single-sample record right after reset.
    '{16'h7FFF, 1'b1, 1'b1, 6'd1},
    // Short record of four samples: nothing until the end, then four zeros.
    '{16'h8000, 1'b0, 1'b1, 6'd0},
    '{16'h5555, 1'b0, 1'b1, 6'd0},
    '{16'hAAAA, 1'b0, 1'b1, 6'd0},
    '{16'hFFFF, 1'b1, 1'b1, 6'd4},
    // Next record starts from a cleared count.
    '{16'h0000, 1'b1, 1'b1, 6'd1},
    '{16'h0001, 1'b0, 1'b1, 6'd0},
    '{16'h7FFF, 1'b0, 1'b1, 6'd0},
    '{16'h8000, 1'b1, 1'b1, 6'd3}
  };

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  sgcd_in_t  in_req_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  sgcd_out_t out_rsp_o;

  // Predictor state: coefficient rows, sample window and record position.
  longint                  d1_taps [TAPS];
  longint                  d2_taps [TAPS];
  logic signed [15:0]      smp_win [TAPS];
  int                      rec_count = 0;
  sgcd_out_t               step_q [$];
  sgcd_out_t               deriv_q [$];
  sgcd_out_t               want_rsp;

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int sent_cnt      = 0;
  int mismatch_cnt  = 0;
  int cycle_cnt     = 0;

  savgol_cubic_derivative_fir DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $realtime, msg);
    mismatch_cnt++;
  endtask

  // Rounds num * 2^FRAC / den to nearest, ties away from zero.
  function automatic longint round_scaled(input longint num, input longint den);
    logic [127:0] mag;
    logic [127:0] quo;
    mag = (num < 0) ? 128'(-num) : 128'(num);
    quo = (((mag << (FRAC + 1)) / 128'(den)) + 128'd1) >> 1;
    return (num < 0) ? -longint'(quo[63:0]) : longint'(quo[63:0]);
  endfunction

  // Cubic smoothing derivative weights, oldest tap first (offset -HALF).
  function automatic void build_taps();
    longint m;
    longint m2;
    longint m4;
    longint den1;
    longint den2;
    longint i;
    m    = longint'(WINDOW_POINTS_DEF);
    m2   = m * m;
    m4   = m2 * m2;
    den1 = m * (m2 - 1) * (3 * m4 - 39 * m2 + 108);
    den2 = m * (m2 - 1) * (m2 - 4);
    for (int j = 0; j < TAPS; j++) begin
      i = longint'(j - HALF);
      d1_taps[j] = round_scaled(15 * (5 * (3 * m4 - 18 * m2 + 31) * i
                                      - 28 * (3 * m2 - 7) * i * i * i), den1);
      d2_taps[j] = round_scaled(30 * (12 * i * i - (m2 - 1)), den2);
      smp_win[j] = '0;
    end
  endfunction

  // Exact dot product of one weight row with the window, saturated to 56 bits.
  function automatic logic signed [OUT_W-1:0] fir_dot(input bit second);
    logic signed [127:0] acc;
    logic signed [127:0] c;
    acc = '0;
    for (int j = 0; j < TAPS; j++) begin
      c   = second ? 128'(d2_taps[j]) : 128'(d1_taps[j]);
      acc = acc + c * 128'(smp_win[j]);
    end
    if (acc > SAT_HI) return OUT_MAX;
    if (acc < SAT_LO) return OUT_MIN;
    return acc[OUT_W-1:0];
  endfunction

  // Advances the predictor by one sample and leaves its results in step_q.
  function automatic void predict_derivs(input sgcd_in_t item);
    int        n;
    int        extra;
    sgcd_out_t r;
    n = rec_count;
    for (int j = 0; j + 1 < TAPS; j++) smp_win[j] = smp_win[j + 1];
    smp_win[TAPS-1] = item.sample;
    step_q.delete();
    // The center of the window has a result once HALF samples came before it;
    // it is nonzero only when the whole window lies inside the record.
    if (n >= HALF) begin
      r.first_derivative  = (n >= 2 * HALF) ? fir_dot(1'b0) : '0;
      r.second_derivative = (n >= 2 * HALF) ? fir_dot(1'b1) : '0;
      r.final_result      = 1'b0;
      step_q = {step_q, r};
    end
    // A record end flushes the trailing edge positions as zeros.
    if (item.record_end) begin
      extra = (n >= HALF) ? HALF : n + 1;
      for (int k = 0; k < extra; k++) begin
        r = '0;
        r.final_result = (k == extra - 1);
        step_q = {step_q, r};
      end
      rec_count = 0;
    end else if (n < 2 * HALF) begin
      rec_count = n + 1;
    end
  endfunction

  // Offers one sample request, waits for it to be taken and queues its results.
  task automatic push_sample(input sgcd_in_t item, input bit typed, input int zeros);
    sgcd_out_t z;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= item;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sent_cnt++;
    predict_derivs(item);
    if (typed) begin
      for (int k = 0; k < zeros; k++) begin
        z = '0;
        z.final_result = item.record_end && (k == zeros - 1);
        deriv_q = {deriv_q, z};
      end
    end else begin
      deriv_q = {deriv_q, step_q};
    end
  endtask

  // Receiver back-pressure.
  always @(posedge clk_i) begin
    out_stall_i <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  // Result checker: every accepted result request against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (deriv_q.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected: d1=%0d d2=%0d fin=%0b",
                                  out_rsp_o.first_derivative,
                                  out_rsp_o.second_derivative,
                                  out_rsp_o.final_result));
      end else begin
        want_rsp = deriv_q.pop_front();
        if (out_rsp_o.first_derivative !== want_rsp.first_derivative ||
            out_rsp_o.second_derivative !== want_rsp.second_derivative ||
            out_rsp_o.final_result !== want_rsp.final_result) begin
          report_mismatch($sformatf("d1=%0d/%0d d2=%0d/%0d fin=%0b/%0b (got/exp)",
                                    out_rsp_o.first_derivative,
                                    want_rsp.first_derivative,
                                    out_rsp_o.second_derivative,
                                    want_rsp.second_derivative,
                                    out_rsp_o.final_result,
                                    want_rsp.final_result));
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    sgcd_in_t item;
    int       phase_goal;
    int       len;
    int       style;
    int       pick;
    int       base;
    int       slope;
    int       curv;
    int       v;
    build_taps();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed table, no idling.
    for (int r = 0; r < DIR_ROWS; r++) begin
      item.sample     = DIR_TAB[r].sample;
      item.record_end = DIR_TAB[r].last;
      push_sample(item, DIR_TAB[r].typed, int'(DIR_TAB[r].zeros));
    end

    // Random records, one idling pattern per phase.
    for (int ph = 0; ph < PHASES; ph++) begin
      send_idle_pct = SEND_IDLE[ph];
      stall_pct     = RECV_STALL[ph];
      phase_goal    = sent_cnt + RAND_ITEMS / PHASES;
      while (sent_cnt < phase_goal) begin
        // Mostly full-window records; short and edge-only ones as noise.
        pick = $urandom_range(99);
        if (pick < 15) len = $urandom_range(HALF, 1);
        else if (pick < 30) len = $urandom_range(2 * HALF + 1, HALF + 1);
        else len = $urandom_range(2 * HALF + 60, 2 * HALF + 2);
        // The last record of a phase is cut to what is left of its share.
        if (len > phase_goal - sent_cnt) len = phase_goal - sent_cnt;
        pick = $urandom_range(99);
        if (pick < 40) style = 0;
        else if (pick < 70) style = 2;
        else if (pick < 85) style = 3;
        else style = 1;
        base  = int'($urandom_range(65535)) - 32768;
        slope = int'($urandom_range(1024)) - 512;
        curv  = int'($urandom_range(256)) - 128;
        for (int k = 0; k < len; k++) begin
          if (style == 0) begin
            item.sample = 16'($urandom());
          end else if (style == 1) begin
            case ($urandom_range(3))
              0:       item.sample = 16'h7FFF;
              1:       item.sample = 16'h8000;
              2:       item.sample = 16'h0000;
              default: item.sample = 16'hFFFF;
            endcase
          end else begin
            // Smooth polynomial or low noise around an offset, clipped to range.
            if (style == 2) v = base + slope * k + (curv * k * k) / 64;
            else v = base + int'($urandom_range(32)) - 16;
            if (v > 32767) v = 32767;
            if (v < -32768) v = -32768;
            item.sample = v[15:0];
          end
          item.record_end = (k == len - 1);
          push_sample(item, 1'b0, 0);
        end
      end
      // Sender holds off until every outstanding result has come back.
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while (deriv_q.size() != 0) @(posedge clk_i);
    end

    repeat (LINGER) @(posedge clk_i);
    if (deriv_q.size() != 0) begin
      report_mismatch($sformatf("%0d expected results never arrived", deriv_q.size()));
    end
    if (mismatch_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
